// ===== hdl/fp16mm_pkg.sv =====
// Shared constants, types and helper functions of the FP16 transposed matrix product core.
package fp16mm_pkg;

   // Matrix capacity.
   localparam int MAX_M = 64;
   localparam int MAX_N = 64;
   localparam int MAX_P = 64;

   // Field widths.
   localparam int COUNT_W = 7;
   localparam int IDX_W   = 6;
   localparam int FP_W    = 16;
   localparam int OP_W    = 2;

   // Element stores.
   localparam int A_DEPTH  = MAX_M * MAX_N;
   localparam int B_DEPTH  = MAX_M * MAX_P;
   localparam int A_ADDR_W = $clog2(A_DEPTH);
   localparam int B_ADDR_W = $clog2(B_DEPTH);
   localparam int M_IDX_W  = $clog2(MAX_M);

   // Register port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_M_COUNT = 2'd0;
   localparam logic [1:0] REG_N_COUNT = 2'd1;
   localparam logic [1:0] REG_P_COUNT = 2'd2;

   // Operation codes of an input transfer.
   localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
   localparam logic [OP_W-1:0] OP_READ    = 2'd2;

   // FP16 constants.
   localparam logic [FP_W-1:0] QNAN16     = 16'h7E00;
   localparam logic [FP_W-2:0] INF_MAG16  = 15'h7C00;
   localparam logic [FP_W-1:0] NEG_ZERO16 = 16'h8000;

   // Width of the aligned significand datapath and the far-alignment limit.
   localparam int MAG_W       = 58;
   localparam int ALIGN_EXTRA = 38;

   typedef enum logic [2:0] {
      C_IDLE,
      C_FETCH,
      C_START,
      C_WAIT,
      C_SCALE,
      C_SCALE_WAIT,
      C_DONE
   } core_state_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_ALIGN,
      F_ADD,
      F_LZC1,
      F_LZC2,
      F_ROUND
   } fma_state_type;

   // Request to the shared fused multiply-add unit: c + x * y.
   typedef struct packed {
      logic            start;
      logic [FP_W-1:0] x;
      logic [FP_W-1:0] y;
      logic [FP_W-1:0] c;
   } fma_req_type;

   typedef struct packed {
      logic            done;
      logic [FP_W-1:0] value;
   } fma_rsp_type;

   function automatic logic h_is_nan(logic [FP_W-1:0] h);
      return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
   endfunction

   function automatic logic h_is_inf(logic [FP_W-1:0] h);
      return (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
   endfunction

   function automatic logic h_is_zero(logic [FP_W-1:0] h);
      return h[14:0] == 15'd0;
   endfunction

   // Significand of a finite value, with the hidden bit for normals.
   function automatic logic [10:0] h_sig(logic [FP_W-1:0] h);
      return (h[14:10] == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
   endfunction

   // Exponent of the significand's least significant bit.
   function automatic logic signed [7:0] h_exp(logic [FP_W-1:0] h);
      return (h[14:10] == 5'd0) ? -8'sd24 : ($signed({3'b000, h[14:10]}) - 8'sd25);
   endfunction

   // FP16 of 1/m rounded to nearest even, by restoring long division.
   function automatic logic [FP_W-1:0] recip_fp16(int m);
      int          k;
      logic [31:0] num;
      logic [31:0] q;
      logic [31:0] r;
      k   = 10 + $clog2(m);
      num = 32'd1 << k;
      q   = 32'd0;
      r   = 32'd0;
      for (int i = 31; i >= 0; i--) begin
         r = {r[30:0], num[i]};
         q = q << 1;
         if (r >= 32'(m)) begin
            r    = r - 32'(m);
            q[0] = 1'b1;
         end
      end
      if ((2 * r > 32'(m)) || ((2 * r == 32'(m)) && q[0])) begin
         q = q + 32'd1;
      end
      if (q == 32'd2048) begin
         q = 32'd1024;
         k = k - 1;
      end
      return {1'b0, 5'(25 - k), q[9:0]};
   endfunction

   typedef logic [FP_W-1:0] recip_table_type [MAX_M];

   function automatic recip_table_type build_recip_table();
      recip_table_type t;
      for (int i = 0; i < MAX_M; i++) begin
         t[i] = recip_fp16(i + 1);
      end
      return t;
   endfunction

   // Scale factor 1/M, indexed by M-1.
   localparam recip_table_type RECIP_TABLE = build_recip_table();

endpackage

// ===== hdl/fp16_transposed_matmul_scaled_core.sv =====
// Top level: element stores, register port and read sequencer around the shared FMA unit.
// Writes of A or B elements are taken one per cycle while no read is in progress and give no result.
// A read in range runs M multiply-add steps, each a fetch, a start and a wait state on the FMA
// unit, then the 1/M scale pass. The done state loads a result once the output register is free.
// A read out of range, or with M of zero, goes straight to the done state without a step.
// Synchronous reset clears the counts and control state; the stores keep their contents.
module fp16_transposed_matmul_scaled_core (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fp16mm_pkg::OP_W-1:0]         req_op,
   input  logic [fp16mm_pkg::IDX_W-1:0]        req_row,
   input  logic [fp16mm_pkg::IDX_W-1:0]        req_col,
   input  logic [fp16mm_pkg::FP_W-1:0]         req_value,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fp16mm_pkg::FP_W-1:0]         rsp_result,
   output logic                                rsp_out_of_range,
   // Register port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fp16mm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fp16mm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fp16mm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                pready
);
   import fp16mm_pkg::*;

   // Configuration registers.
   logic [COUNT_W-1:0] m_count_ff, n_count_ff, p_count_ff;
   logic               csr_write;
   logic [1:0]         csr_index;

   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_count_ff <= '0;
         n_count_ff <= '0;
         p_count_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_M_COUNT: m_count_ff <= pwdata[COUNT_W-1:0];
            REG_N_COUNT: n_count_ff <= pwdata[COUNT_W-1:0];
            REG_P_COUNT: p_count_ff <= pwdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_M_COUNT: prdata = CSR_DATA_W'(m_count_ff);
         REG_N_COUNT: prdata = CSR_DATA_W'(n_count_ff);
         REG_P_COUNT: prdata = CSR_DATA_W'(p_count_ff);
         default:     prdata = '0;
      endcase
   end

   // Counts saturated at the store capacity.
   logic [COUNT_W-1:0] mm, nn, pp, mm_m1;

   assign mm    = (m_count_ff > COUNT_W'(MAX_M)) ? COUNT_W'(MAX_M) : m_count_ff;
   assign nn    = (n_count_ff > COUNT_W'(MAX_N)) ? COUNT_W'(MAX_N) : n_count_ff;
   assign pp    = (p_count_ff > COUNT_W'(MAX_P)) ? COUNT_W'(MAX_P) : p_count_ff;
   assign mm_m1 = mm - COUNT_W'(1);

   // Sequencer registers.
   core_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   n_ff, n_in, p_ff, p_in;
   logic [COUNT_W-1:0] m_ff, m_in;
   logic [FP_W-1:0]    acc_ff, acc_in;
   logic               oor_ff, oor_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FP_W-1:0]    rsp_result_ff, rsp_result_in;
   logic               rsp_oor_ff, rsp_oor_in;

   // Store ports.
   logic                a_we, b_we;
   logic [A_ADDR_W-1:0] a_wr_addr, a_rd_addr;
   logic [B_ADDR_W-1:0] b_wr_addr, b_rd_addr;
   logic [FP_W-1:0]     a_rd_data, b_rd_data;

   assign a_wr_addr = A_ADDR_W'(req_row) * A_ADDR_W'(MAX_N) + A_ADDR_W'(req_col);
   assign b_wr_addr = B_ADDR_W'(req_row) * B_ADDR_W'(MAX_P) + B_ADDR_W'(req_col);
   assign a_rd_addr = A_ADDR_W'(m_ff[M_IDX_W-1:0]) * A_ADDR_W'(MAX_N) + A_ADDR_W'(n_ff);
   assign b_rd_addr = B_ADDR_W'(m_ff[M_IDX_W-1:0]) * B_ADDR_W'(MAX_P) + B_ADDR_W'(p_ff);

   fp16mm_ram #(
      .WIDTH(FP_W),
      .DEPTH(A_DEPTH)
   ) u_a_store (
      .clock  (clock),
      .wr_en  (a_we),
      .wr_addr(a_wr_addr),
      .wr_data(req_value),
      .rd_addr(a_rd_addr),
      .rd_data(a_rd_data)
   );

   fp16mm_ram #(
      .WIDTH(FP_W),
      .DEPTH(B_DEPTH)
   ) u_b_store (
      .clock  (clock),
      .wr_en  (b_we),
      .wr_addr(b_wr_addr),
      .wr_data(req_value),
      .rd_addr(b_rd_addr),
      .rd_data(b_rd_data)
   );

   // Shared multiply-add unit; the scale pass is x * (1/M) with a negative zero addend.
   fma_req_type fma_req;
   fma_rsp_type fma_rsp;

   fp16mm_fma u_fma (
      .clock  (clock),
      .reset  (reset),
      .fma_req(fma_req),
      .fma_rsp(fma_rsp)
   );

   always_comb begin
      fma_req.start = (state_ff == C_START) || (state_ff == C_SCALE);
      if (state_ff == C_SCALE) begin
         fma_req.x = acc_ff;
         fma_req.y = RECIP_TABLE[mm_m1[M_IDX_W-1:0]];
         fma_req.c = NEG_ZERO16;
      end else begin
         fma_req.x = a_rd_data;
         fma_req.y = b_rd_data;
         fma_req.c = acc_ff;
      end
   end

   logic req_xfer, rsp_xfer, out_free;

   assign req_stall = (state_ff != C_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Next state, store writes and result loads.
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      p_in          = p_ff;
      m_in          = m_ff;
      acc_in        = acc_ff;
      oor_in        = oor_ff;
      a_we          = 1'b0;
      b_we          = 1'b0;
      rsp_valid_in  = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_oor_in    = rsp_oor_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (req_xfer) begin
               unique case (req_op)
                  OP_WRITE_A: begin
                     a_we = (COUNT_W'(req_row) < mm) && (COUNT_W'(req_col) < nn);
                  end
                  OP_WRITE_B: begin
                     b_we = (COUNT_W'(req_row) < mm) && (COUNT_W'(req_col) < pp);
                  end
                  OP_READ: begin
                     n_in   = req_row;
                     p_in   = req_col;
                     m_in   = '0;
                     acc_in = '0;
                     oor_in = (COUNT_W'(req_row) >= nn) || (COUNT_W'(req_col) >= pp);
                     if ((COUNT_W'(req_row) >= nn) || (COUNT_W'(req_col) >= pp) ||
                         (mm == '0)) begin
                        state_in = C_DONE;
                     end else begin
                        state_in = C_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         C_FETCH: begin
            state_in = C_START;
         end
         C_START: begin
            state_in = C_WAIT;
         end
         C_WAIT: begin
            if (fma_rsp.done) begin
               acc_in = fma_rsp.value;
               m_in   = m_ff + COUNT_W'(1);
               if (m_ff + COUNT_W'(1) == mm) begin
                  state_in = C_SCALE;
               end else begin
                  state_in = C_FETCH;
               end
            end
         end
         C_SCALE: begin
            state_in = C_SCALE_WAIT;
         end
         C_SCALE_WAIT: begin
            if (fma_rsp.done) begin
               acc_in   = fma_rsp.value;
               state_in = C_DONE;
            end
         end
         C_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = oor_ff ? '0 : acc_ff;
               rsp_oor_in    = oor_ff;
               state_in      = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      p_ff          <= p_in;
      m_ff          <= m_in;
      acc_ff        <= acc_in;
      oor_ff        <= oor_in;
      rsp_result_ff <= rsp_result_in;
      rsp_oor_ff    <= rsp_oor_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result       = rsp_result_ff;
   assign rsp_out_of_range = rsp_oor_ff;

`ifndef SYNTHESIS
   // An out-of-range result always carries a zero value.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_out_of_range || (rsp_result == '0)))
      else $error("out-of-range result with nonzero value");

   // The reduction index stays below M while a step is in flight.
   a_m_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_WAIT) |-> (m_ff < mm))
      else $error("reduction index beyond M");

   // The FMA unit only finishes while the sequencer waits for it.
   a_fma_done: assert property (@(posedge clock) disable iff (reset)
      fma_rsp.done |-> ((state_ff == C_WAIT) || (state_ff == C_SCALE_WAIT)))
      else $error("unexpected FMA completion");

   // Store writes happen only from an accepted transfer in idle.
   a_store_write: assert property (@(posedge clock) disable iff (reset)
      (a_we || b_we) |-> (req_xfer && (state_ff == C_IDLE)))
      else $error("store write outside an accepted transfer");
`endif

endmodule

// ===== hdl/fp16mm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fp16mm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fp16mm_fma.sv =====
// Multi-cycle FP16 fused multiply-add unit, c + x * y rounded once to nearest even.
module fp16mm_fma (
   input  logic                    clock,
   input  logic                    reset,
   input  fp16mm_pkg::fma_req_type fma_req,
   output fp16mm_pkg::fma_rsp_type fma_rsp
);
   import fp16mm_pkg::*;

   fma_state_type      state_ff, state_in;
   logic [FP_W-1:0]    x_ff, x_in, y_ff, y_in, c_ff, c_in;
   logic [21:0]        pm_ff, pm_in;
   logic signed [7:0]  pe_ff, pe_in, ce_ff, ce_in, e_ff, e_in;
   logic               ps_ff, ps_in, cs_ff, cs_in;
   logic [10:0]        cm_ff, cm_in;
   logic [MAG_W-1:0]   him_ff, him_in, lom_ff, lom_in, mag_ff, mag_in;
   logic               his_ff, his_in, los_ff, los_in, neg_ff, neg_in;
   logic [2:0]         chunk_ff, chunk_in;
   logic [5:0]         msb_ff, msb_in;
   logic [FP_W-1:0]    res_ff, res_in;
   logic               done_ff, done_in;

   // Operand decode of the latched inputs.
   logic              x_nan, y_nan, c_nan, x_inf, y_inf, c_inf, x_zero, y_zero, c_zero;
   logic              prod_sign;
   logic [21:0]       prod;
   logic signed [7:0] prod_exp;

   assign x_nan     = h_is_nan(x_ff);
   assign y_nan     = h_is_nan(y_ff);
   assign c_nan     = h_is_nan(c_ff);
   assign x_inf     = h_is_inf(x_ff);
   assign y_inf     = h_is_inf(y_ff);
   assign c_inf     = h_is_inf(c_ff);
   assign x_zero    = h_is_zero(x_ff);
   assign y_zero    = h_is_zero(y_ff);
   assign c_zero    = h_is_zero(c_ff);
   assign prod_sign = x_ff[15] ^ y_ff[15];
   assign prod      = {11'd0, h_sig(x_ff)} * {11'd0, h_sig(y_ff)};
   assign prod_exp  = h_exp(x_ff) + h_exp(y_ff);

   // Alignment of the product and the addend to a common exponent.
   logic [MAG_W-1:0]  al_hi, al_lo, al_him, al_lom;
   logic signed [7:0] al_hie, al_loe, al_e;
   logic              al_his, al_los;
   logic signed [8:0] al_diff9;
   logic [5:0]        al_diff, al_s;

   always_comb begin
      if (pe_ff >= ce_ff) begin
         al_hi  = MAG_W'(pm_ff);
         al_hie = pe_ff;
         al_his = ps_ff;
         al_lo  = MAG_W'(cm_ff);
         al_loe = ce_ff;
         al_los = cs_ff;
      end else begin
         al_hi  = MAG_W'(cm_ff);
         al_hie = ce_ff;
         al_his = cs_ff;
         al_lo  = MAG_W'(pm_ff);
         al_loe = pe_ff;
         al_los = ps_ff;
      end
      al_diff9 = {al_hie[7], al_hie} - {al_loe[7], al_loe};
      al_diff  = al_diff9[5:0];
      al_s     = al_diff - 6'(ALIGN_EXTRA);
      if (al_diff > 6'(ALIGN_EXTRA)) begin
         // Far case: the smaller term shifts down, its lost bits ORed in as sticky.
         al_him = al_hi << ALIGN_EXTRA;
         al_e   = al_hie - 8'(ALIGN_EXTRA);
         al_lom = (al_lo >> al_s) | MAG_W'(|(al_lo & ~({MAG_W{1'b1}} << al_s)));
      end else begin
         al_him = al_hi << al_diff;
         al_e   = al_loe;
         al_lom = al_lo;
      end
   end

   // Signed magnitude addition.
   logic [MAG_W-1:0] add_mag;
   logic             add_neg;

   always_comb begin
      if (his_ff == los_ff) begin
         add_mag = him_ff + lom_ff;
         add_neg = his_ff;
      end else if (him_ff >= lom_ff) begin
         add_mag = him_ff - lom_ff;
         add_neg = his_ff;
      end else begin
         add_mag = lom_ff - him_ff;
         add_neg = los_ff;
      end
   end

   // Leading-one search, first by byte and then by bit within the byte.
   logic [63:0] mag64;
   logic [7:0]  lz_byte;
   logic [2:0]  lz_chunk, lz_bit;

   assign mag64   = {(64 - MAG_W)'(0), mag_ff};
   assign lz_byte = mag64[{chunk_ff, 3'b000} +: 8];

   always_comb begin
      lz_chunk = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (mag64[8*i +: 8] != 8'd0) begin
            lz_chunk = 3'(i);
         end
      end
   end

   always_comb begin
      lz_bit = 3'd0;
      for (int j = 0; j < 8; j++) begin
         if (lz_byte[j]) begin
            lz_bit = 3'(j);
         end
      end
   end

   // Rounding to nearest even and packing.
   logic signed [8:0] rd_e9, rd_q, rd_qc, rd_sh, rd_qf, rd_bexp;
   logic [3:0]        rd_nsh;
   logic [5:0]        rd_shm1;
   logic [MAG_W-1:0]  rd_shifted;
   logic              rd_guard, rd_sticky;
   logic [11:0]       rd_sig;
   logic [FP_W-1:0]   rd_result;

   always_comb begin
      rd_e9      = {e_ff[7], e_ff};
      rd_q       = $signed({3'b000, msb_ff}) + rd_e9 - 9'sd10;
      rd_qc      = (rd_q < -9'sd24) ? -9'sd24 : rd_q;
      rd_sh      = rd_qc - rd_e9;
      rd_nsh     = 4'd0;
      rd_shm1    = 6'd0;
      rd_shifted = mag_ff;
      rd_guard   = 1'b0;
      rd_sticky  = 1'b0;
      if (rd_sh <= 9'sd0) begin
         rd_nsh = 4'(-rd_sh);
         rd_sig = mag_ff[11:0] << rd_nsh;
      end else begin
         rd_shm1    = 6'(rd_sh - 9'sd1);
         rd_shifted = mag_ff >> rd_shm1;
         rd_guard   = rd_shifted[0];
         rd_sticky  = |(mag_ff & ~({MAG_W{1'b1}} << rd_shm1));
         rd_sig     = rd_shifted[12:1];
         rd_sig     = rd_sig + 12'(rd_guard & (rd_sticky | rd_sig[0]));
      end
      rd_qf = rd_qc;
      if (rd_sig == 12'd2048) begin
         rd_sig = 12'd1024;
         rd_qf  = rd_qc + 9'sd1;
      end
      rd_bexp = rd_qf + 9'sd25;
      if (rd_sig < 12'd1024) begin
         rd_result = {neg_ff, 5'd0, rd_sig[9:0]};
      end else if (rd_bexp >= 9'sd31) begin
         rd_result = {neg_ff, INF_MAG16};
      end else begin
         rd_result = {neg_ff, rd_bexp[4:0], rd_sig[9:0]};
      end
   end

   // Sequencer: next state and register loads.
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      c_in     = c_ff;
      pm_in    = pm_ff;
      pe_in    = pe_ff;
      ps_in    = ps_ff;
      cm_in    = cm_ff;
      ce_in    = ce_ff;
      cs_in    = cs_ff;
      him_in   = him_ff;
      lom_in   = lom_ff;
      e_in     = e_ff;
      his_in   = his_ff;
      los_in   = los_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      chunk_in = chunk_ff;
      msb_in   = msb_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (fma_req.start) begin
               x_in     = fma_req.x;
               y_in     = fma_req.y;
               c_in     = fma_req.c;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            priority if (x_nan || y_nan || c_nan) begin
               res_in   = QNAN16;
               done_in  = 1'b1;
               state_in = F_IDLE;
            end else if (x_inf || y_inf) begin
               if (x_zero || y_zero || (c_inf && (c_ff[15] != prod_sign))) begin
                  res_in = QNAN16;
               end else begin
                  res_in = {prod_sign, INF_MAG16};
               end
               done_in  = 1'b1;
               state_in = F_IDLE;
            end else if (c_inf) begin
               res_in   = c_ff;
               done_in  = 1'b1;
               state_in = F_IDLE;
            end else if (x_zero || y_zero) begin
               res_in   = c_zero ? {prod_sign & c_ff[15], 15'd0} : c_ff;
               done_in  = 1'b1;
               state_in = F_IDLE;
            end else begin
               pm_in = prod;
               pe_in = prod_exp;
               ps_in = prod_sign;
               cm_in = h_sig(c_ff);
               ce_in = h_exp(c_ff);
               cs_in = c_ff[15];
               if (c_zero) begin
                  // A zero addend leaves the product to be rounded alone.
                  mag_in   = MAG_W'(prod);
                  e_in     = prod_exp;
                  neg_in   = prod_sign;
                  state_in = F_LZC1;
               end else begin
                  state_in = F_ALIGN;
               end
            end
         end
         F_ALIGN: begin
            him_in   = al_him;
            lom_in   = al_lom;
            e_in     = al_e;
            his_in   = al_his;
            los_in   = al_los;
            state_in = F_ADD;
         end
         F_ADD: begin
            mag_in = add_mag;
            neg_in = add_neg;
            if (add_mag == MAG_W'(0)) begin
               // Exact cancellation gives positive zero.
               res_in   = 16'h0000;
               done_in  = 1'b1;
               state_in = F_IDLE;
            end else begin
               state_in = F_LZC1;
            end
         end
         F_LZC1: begin
            chunk_in = lz_chunk;
            state_in = F_LZC2;
         end
         F_LZC2: begin
            msb_in   = {chunk_ff, lz_bit};
            state_in = F_ROUND;
         end
         F_ROUND: begin
            res_in   = rd_result;
            done_in  = 1'b1;
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      c_ff     <= c_in;
      pm_ff    <= pm_in;
      pe_ff    <= pe_in;
      ps_ff    <= ps_in;
      cm_ff    <= cm_in;
      ce_ff    <= ce_in;
      cs_ff    <= cs_in;
      him_ff   <= him_in;
      lom_ff   <= lom_in;
      e_ff     <= e_in;
      his_ff   <= his_in;
      los_ff   <= los_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      chunk_ff <= chunk_in;
      msb_ff   <= msb_in;
      res_ff   <= res_in;
   end

   assign fma_rsp.done  = done_ff;
   assign fma_rsp.value = res_ff;

endmodule
